@@ hw/rtl/decimated_crc16_frame_builder_top_defines.svh @@
// Assertion macros shared by the frame builder checker.
`ifndef DECIMATED_CRC16_FRAME_BUILDER_TOP_DEFINES_SVH
`define DECIMATED_CRC16_FRAME_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DCFB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DCFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

@@ hw/rtl/dcfb_pkg.sv @@
// Types, codes and CRC helper for the decimated CRC16 frame builder.
package dcfb_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LEN = 2'd2;
  localparam logic [1:0] REG_DECIMATION  = 2'd3;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_CRC     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       byte_kind;
    logic        frame_end;
    logic        run_last;
    logic [31:0] loop_count;
    logic [31:0] drop_count;
  } beat_t;

  // CRC16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/decimated_crc16_frame_builder_top.sv @@
// Top level of the decimated sync/length/payload/CRC16 frame builder.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------------
//   in_      | in  | in_tvalid/in_tready  | tuser=func, tdata={tx_busy,data_byte}
//   out_     | out | out_tvalid/out_tready| tdata={drop,loop,byte} tuser={end,kind}
//   cfg_     | in  | APB, pready tied 1   | 4 regs at 0x0,0x4,0x8,0xC
//
// An accepted beat is fully processed in its acceptance cycle; its 0..3 result
// beats land in a 4-entry result queue, which drains one beat per cycle; output
// stalls back up the queue. in_tready is high while the queue holds at most one
// beat, so while the output drains, items that make zero or one result flow at
// one per cycle; a frame header or the payload beat that closes a frame (three
// results) holds the input until the queue is down to one beat. Reset (rst_n low,
// synchronous) clears counters and the queue and loads the register defaults.
module decimated_crc16_frame_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] tx_busy, [15:9] zero
  input  logic        in_tuser,   // [0] func: 0 control tick, 1 payload byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [39:8] loop_count, [71:40] drop_count
  output logic [2:0]  out_tuser,  // [1:0] byte_kind, [2] frame_end
  output logic        out_tlast,  // run_last: last beat caused by one input beat
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  logic [7:0]  sync_first_r, sync_second_r, payload_len_r;
  logic [15:0] decimation_r;

  // Frame state
  logic [31:0] tick_r, tick_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [31:0] drop_r, drop_nxt;
  logic        open_r, open_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;

  // Result queue
  dcfb_pkg::beat_t q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  dcfb_pkg::beat_t res [3];
  logic [1:0]  n_res;
  logic        in_fire, out_fire, cfg_wr;
  logic [16:0] phase_sum;
  logic [7:0]  left_v;
  logic [15:0] crc_v;
  logic        func;
  logic [7:0]  data_byte;
  logic        tx_busy;

  assign func      = in_tuser;
  assign data_byte = in_tdata[7:0];
  assign tx_busy   = in_tdata[8];

  assign in_tready = (cnt_r <= 3'd1);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_fire  = out_tvalid && out_tready;

  assign out_tdata = {q_r[rd_ptr_r].drop_count, q_r[rd_ptr_r].loop_count,
                      q_r[rd_ptr_r].out_byte};
  assign out_tuser = {q_r[rd_ptr_r].frame_end, q_r[rd_ptr_r].byte_kind};
  assign out_tlast = q_r[rd_ptr_r].run_last;

  // APB
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      dcfb_pkg::REG_SYNC_FIRST:  cfg_prdata = {24'd0, sync_first_r};
      dcfb_pkg::REG_SYNC_SECOND: cfg_prdata = {24'd0, sync_second_r};
      dcfb_pkg::REG_PAYLOAD_LEN: cfg_prdata = {24'd0, payload_len_r};
      dcfb_pkg::REG_DECIMATION:  cfg_prdata = {16'd0, decimation_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // Per-beat processing: state update and up to three results.
  always_comb begin
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    drop_nxt  = drop_r;
    open_nxt  = open_r;
    left_nxt  = left_r;
    crc_nxt   = crc_r;
    n_res     = 2'd0;
    phase_sum = {1'b0, phase_r} + 17'd1;
    left_v    = left_r - 8'd1;
    crc_v     = dcfb_pkg::crc_byte(crc_r, data_byte);
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    if (in_fire) begin
      if (!func) begin
        tick_nxt = tick_r + 32'd1;
        // decimation of zero acts as one: phase_sum is never below it
        if (phase_sum >= {1'b0, decimation_r}) begin
          phase_nxt = '0;
          if (tx_busy || open_r) begin
            drop_nxt = drop_r + 32'd1;
          end else begin
            res[0].out_byte  = sync_first_r;
            res[0].byte_kind = dcfb_pkg::KIND_HEADER;
            res[1].out_byte  = sync_second_r;
            res[1].byte_kind = dcfb_pkg::KIND_HEADER;
            res[2].out_byte  = payload_len_r;
            res[2].byte_kind = dcfb_pkg::KIND_HEADER;
            n_res    = 2'd3;
            crc_nxt  = dcfb_pkg::crc_byte(dcfb_pkg::CRC_INIT, payload_len_r);
            left_nxt = payload_len_r;
            open_nxt = 1'b1;
          end
        end else begin
          phase_nxt = phase_sum[15:0];
        end
      end else if (open_r) begin
        if (left_r != 8'd0) begin
          res[0].out_byte  = data_byte;
          res[0].byte_kind = dcfb_pkg::KIND_PAYLOAD;
          if (left_v == 8'd0) begin
            // last payload byte: trailer follows in the same run
            res[1].out_byte  = crc_v[7:0];
            res[1].byte_kind = dcfb_pkg::KIND_CRC;
            res[2].out_byte  = crc_v[15:8];
            res[2].byte_kind = dcfb_pkg::KIND_CRC;
            res[2].frame_end = 1'b1;
            n_res    = 2'd3;
            open_nxt = 1'b0;
            crc_nxt  = dcfb_pkg::CRC_INIT;
          end else begin
            n_res   = 2'd1;
            crc_nxt = crc_v;
          end
          left_nxt = left_v;
        end else begin
          // zero-length frame: trailer only, data byte ignored
          res[0].out_byte  = crc_r[7:0];
          res[0].byte_kind = dcfb_pkg::KIND_CRC;
          res[1].out_byte  = crc_r[15:8];
          res[1].byte_kind = dcfb_pkg::KIND_CRC;
          res[1].frame_end = 1'b1;
          n_res    = 2'd2;
          open_nxt = 1'b0;
          crc_nxt  = dcfb_pkg::CRC_INIT;
        end
      end
    end

    for (int k = 0; k < 3; k++) begin
      res[k].run_last   = (2'(k) == (n_res - 2'd1));
      res[k].loop_count = tick_nxt;
      res[k].drop_count = drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'd170;
      sync_second_r <= 8'd85;
      payload_len_r <= 8'd73;
      decimation_r  <= 16'd2;
      tick_r   <= '0;
      phase_r  <= '0;
      drop_r   <= '0;
      open_r   <= 1'b0;
      left_r   <= '0;
      crc_r    <= dcfb_pkg::CRC_INIT;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          dcfb_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_pwdata[7:0];
          dcfb_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_pwdata[7:0];
          dcfb_pkg::REG_PAYLOAD_LEN: payload_len_r <= cfg_pwdata[7:0];
          dcfb_pkg::REG_DECIMATION:  decimation_r  <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
      drop_r   <= drop_nxt;
      open_r   <= open_nxt;
      left_r   <= left_nxt;
      crc_r    <= crc_nxt;
      wr_ptr_r <= wr_ptr_r + n_res;
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, n_res} - {2'd0, out_fire};
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_res) begin
        q_r[wr_ptr_r + 2'(k)] <= res[k];
      end
    end
  end

endmodule

@@ hw/rtl/dcfb_checker.sv @@
// Port-level checker for the frame builder, bound to the top level.
`include "decimated_crc16_frame_builder_top_defines.svh"

module dcfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [3:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  logic is_crc;
  assign is_crc = (out_tuser[1:0] == dcfb_pkg::KIND_CRC);

  // only the three defined kinds ever leave the block
  `DCFB_ASSERT_IMPL(a_kind_legal, out_tvalid, out_tuser[1:0] != 2'd3)

  // frame end rides on a CRC beat that also closes its run
  `DCFB_ASSERT_IMPL(a_end_on_crc, out_tvalid && out_tuser[2], is_crc && out_tlast)

  // CRC low byte is always followed by the high byte in the same run
  `DCFB_ASSERT_IMPL(a_crc_lo_not_last, out_tvalid && is_crc && !out_tuser[2], !out_tlast)

  // stalled beat holds
  `DCFB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind decimated_crc16_frame_builder_top dcfb_checker u_dcfb_checker (.*);

@@ dv/frame_tb_pkg.sv @@
// Codes shared by the frame builder testbench and its checker.
package frame_tb_pkg;

  // Input beat function select, carried on in_tuser.
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // Register values after reset.
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd85;
  localparam logic [7:0]  PAYLOAD_LEN_RST = 8'd73;
  localparam logic [15:0] DECIMATION_RST  = 16'd2;

endpackage

@@ dv/frame_stream_check.sv @@
// Watches the frame builder channels, predicts each result beat and compares.
module frame_stream_check
  import dcfb_pkg::*;
  import frame_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          beats_checked,
  output int          frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers
  logic [7:0]  sync_a, sync_b, frame_len;
  logic [15:0] decim_cfg;

  // predicted block state
  logic [31:0] ticks_seen, drops_seen;
  logic [15:0] phase, crc_acc;
  logic [7:0]  left;
  logic        open;

  beat_t frame_bytes_due[$];
  int    fails, checked, closed;

  // bit-serial CRC16-CCITT, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic beat_t make_beat(input logic [7:0] val, input kind_t kind,
                                      input logic fend);
    beat_t b;
    b            = '0;
    b.out_byte   = val;
    b.byte_kind  = kind;
    b.frame_end  = fend;
    return b;
  endfunction

  task automatic build_frame_bytes(input logic func, input logic [7:0] data,
                                   input logic busy);
    beat_t       made [3];
    int          n;
    logic [16:0] next_phase;
    n = 0;
    if (func == FUNC_TICK) begin
      next_phase = {1'b0, phase} + 17'd1;
      ticks_seen = ticks_seen + 32'd1;
      if (next_phase >= {1'b0, decim_cfg}) begin
        phase = '0;
        if (busy || open) begin
          drops_seen = drops_seen + 32'd1;
        end else begin
          made[0] = make_beat(sync_a, KIND_HEADER, 1'b0);
          made[1] = make_beat(sync_b, KIND_HEADER, 1'b0);
          made[2] = make_beat(frame_len, KIND_HEADER, 1'b0);
          n       = 3;
          crc_acc = crc16_step(CRC_INIT, frame_len);
          left    = frame_len;
          open    = 1'b1;
        end
      end else begin
        phase = next_phase[15:0];
      end
    end else if (open) begin
      if (left != 0) begin
        made[n] = make_beat(data, KIND_PAYLOAD, 1'b0);
        n++;
        crc_acc = crc16_step(crc_acc, data);
        left    = left - 8'd1;
      end
      if (left == 0) begin
        made[n] = make_beat(crc_acc[7:0], KIND_CRC, 1'b0);
        made[n + 1] = make_beat(crc_acc[15:8], KIND_CRC, 1'b1);
        n += 2;
        open    = 1'b0;
        crc_acc = CRC_INIT;
        closed++;
      end
    end
    for (int k = 0; k < n; k++) begin
      made[k].run_last   = (k == n - 1);
      made[k].loop_count = ticks_seen;
      made[k].drop_count = drops_seen;
      frame_bytes_due.push_back(made[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      sync_a     = SYNC_FIRST_RST;
      sync_b     = SYNC_SECOND_RST;
      frame_len  = PAYLOAD_LEN_RST;
      decim_cfg  = DECIMATION_RST;
      ticks_seen = '0;
      drops_seen = '0;
      phase      = '0;
      left       = '0;
      open       = 1'b0;
      crc_acc    = CRC_INIT;
      frame_bytes_due.delete();
    end else begin
      // results first, so a beat can never match an item accepted on the same edge
      if (out_tvalid && out_tready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("result beat 0x%0h with nothing expected", out_tdata[7:0]);
          fails++;
        end else begin
          want = frame_bytes_due.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_tdata[7:0]));
          check_field("byte_kind", 32'(want.byte_kind), 32'(out_tuser[1:0]));
          check_field("frame_end", 32'(want.frame_end), 32'(out_tuser[2]));
          check_field("run_last", 32'(want.run_last), 32'(out_tlast));
          check_field("loop_count", want.loop_count, out_tdata[39:8]);
          check_field("drop_count", want.drop_count, out_tdata[71:40]);
          checked++;
        end
      end
      if (in_tvalid && in_tready)
        build_frame_bytes(in_tuser, in_tdata[7:0], in_tdata[8]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_SYNC_FIRST:  sync_a    = cfg_pwdata[7:0];
          REG_SYNC_SECOND: sync_b    = cfg_pwdata[7:0];
          REG_PAYLOAD_LEN: frame_len = cfg_pwdata[7:0];
          REG_DECIMATION:  decim_cfg = cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pending       <= frame_bytes_due.size();
    beats_checked <= checked;
    frames_closed <= closed;
  end

endmodule

@@ dv/testbench.sv @@
// Top of the frame builder testbench: clock, reset, stimulus and verdict.
module testbench;
  import dcfb_pkg::*;
  import frame_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 8;       // block finishes an item in its accept cycle
  localparam int HOLD_CYCLES  = 80;      // long receiver hold-off
  localparam int CYCLE_LIMIT  = 400000;  // watchdog

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [15:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  int mismatches, beats_due, beats_checked, frames_closed;

  // idling knobs, per phase
  int sender_idle_pct;
  int stall_pct;
  int holds_asked, holds_served, hold_left;

  // what the stimulus believes is programmed, used to shape frames
  logic [7:0]  cur_len;
  logic [15:0] cur_decim;

  int items_sent;
  int cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  decimated_crc16_frame_builder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  frame_stream_check u_frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .fail_count    (mismatches),
    .pending       (beats_due),
    .beats_checked (beats_checked),
    .frames_closed (frames_closed)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("decimated_crc16_frame_builder_top regression: fail");
      $finish;
    end
  end

  // Receiver. A hold-off request (holds_asked bumped by the stimulus) parks
  // tready low for a hold-off; otherwise it stalls at random per stall_pct.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      holds_served <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One input beat: optional random gap, then hold valid until accepted.
  // Reading in_tready right after the edge sees its value at that edge.
  task automatic send_item(input logic func, input logic [7:0] data, input logic busy);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'd0, busy, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, let every expected beat drain, then a few quiet cycles.
  // First edge lets the checker count the last accepted beat.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup, access (write lands on this edge), then the bus goes idle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_PAYLOAD_LEN) cur_len = val[7:0];
    if (idx == REG_DECIMATION) cur_decim = val[15:0];
  endtask

  task automatic program_all(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] len, input logic [15:0] decim);
    reg_write(REG_SYNC_FIRST, {24'd0, s1});
    reg_write(REG_SYNC_SECOND, {24'd0, s2});
    reg_write(REG_PAYLOAD_LEN, {24'd0, len});
    reg_write(REG_DECIMATION, {16'd0, decim});
  endtask

  // One mostly well-formed frame attempt: enough ticks to hit a decimated one
  // (busy now and then), then the payload. Sometimes a tick lands mid-frame
  // (drop), the payload is cut short, or a stray payload beat follows.
  task automatic send_frame_run(inout int budget);
    int ticks, nbytes, mid;
    ticks  = (cur_decim == 0) ? 1 : cur_decim;
    nbytes = (cur_len == 0) ? 1 : cur_len;
    if (nbytes > 1 && $urandom_range(9) == 0) nbytes--;
    mid = ($urandom_range(9) == 0) ? $urandom_range(nbytes - 1) : -1;
    repeat (ticks) begin
      send_item(FUNC_TICK, 8'($urandom), $urandom_range(99) < 15);
      budget--;
    end
    for (int i = 0; i < nbytes; i++) begin
      if (i == mid) begin
        send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
        budget--;
      end
      send_item(FUNC_PAYLOAD, 8'($urandom), 1'($urandom));
      budget--;
    end
    // stray payload beat, not counted; ignored by the block unless a frame is open
    if ($urandom_range(9) == 0) send_item(FUNC_PAYLOAD, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2,
                           input logic [7:0] len, input logic [15:0] decim,
                           input int idle, input int stall, input int budget);
    program_all(s1, s2, len, decim);
    sender_idle_pct = idle;
    stall_pct       <= stall;
    while (budget > 0) send_frame_run(budget);
    wait_idle();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tuser        = FUNC_TICK;
    in_tdata        = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    holds_asked     = 0;
    items_sent      = 0;
    cur_len         = PAYLOAD_LEN_RST;
    cur_decim       = DECIMATION_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, register defaults (decimation 2, length 73) ----
    send_item(FUNC_PAYLOAD, 8'hFF, 1'b1);  // no frame open: ignored
    send_item(FUNC_TICK, 8'hFF, 1'b1);     // non-decimated, busy unused
    send_item(FUNC_TICK, 8'h00, 1'b1);     // decimated but busy: drop
    send_item(FUNC_TICK, 8'h00, 1'b0);
    send_item(FUNC_TICK, 8'h00, 1'b0);     // header 0xAA 0x55 73
    send_item(FUNC_TICK, 8'h00, 1'b0);
    send_item(FUNC_TICK, 8'h00, 1'b0);     // decimated while frame open: drop
    send_item(FUNC_PAYLOAD, 8'h00, 1'b0);
    send_item(FUNC_PAYLOAD, 8'hFF, 1'b1);
    repeat (71) send_item(FUNC_PAYLOAD, 8'($urandom), 1'($urandom));  // close it
    wait_idle();

    // zero length and zero decimation (acts as one)
    program_all(8'hFF, 8'h00, 8'd0, 16'd0);
    send_item(FUNC_TICK, 8'h00, 1'b0);     // header with length 0
    send_item(FUNC_TICK, 8'h00, 1'b1);     // frame open: drop
    send_item(FUNC_PAYLOAD, 8'h5A, 1'b0);  // CRC bytes only, data ignored
    wait_idle();

    // max decimation, then lowered below the current phase
    program_all(8'h00, 8'hFF, 8'd3, 16'hFFFF);
    repeat (5) send_item(FUNC_TICK, 8'h00, 1'b0);
    wait_idle();
    reg_write(REG_DECIMATION, 32'd2);
    send_item(FUNC_TICK, 8'h00, 1'b0);     // decimated at once, header length 3
    send_item(FUNC_PAYLOAD, 8'h80, 1'b0);
    wait_idle();
    // length changed mid-frame: open frame keeps 3
    reg_write(REG_PAYLOAD_LEN, 32'd1);
    send_item(FUNC_PAYLOAD, 8'h01, 1'b0);
    send_item(FUNC_PAYLOAD, 8'hFE, 1'b1);  // third byte closes the frame
    wait_idle();

    // ---- random phases across the idling modes ----
    run_phase(8'hAA, 8'h55, 8'd4,   16'd1, 0,  0,  10);
    run_phase(8'h3C, 8'hC3, 8'd1,   16'd3, 46, 0,  10);
    run_phase(8'h00, 8'hFF, 8'd9,   16'd2, 0,  46, 10);
    run_phase(8'hFF, 8'h00, 8'd2,   16'd1, 32, 32, 10);
    run_phase(8'h5A, 8'hA5, 8'd0,   16'd1, 0,  0,  10);
    run_phase(8'h81, 8'h7E, 8'd6,   16'd4, 46, 0,  10);
    run_phase(8'hE7, 8'h18, 8'd3,   16'd2, 32, 32, 10);

    // ---- back-pressure: receiver holds off while the sender keeps pushing ----
    program_all(8'hC0, 8'h03, 8'd0, 16'd0);
    sender_idle_pct = 0;
    stall_pct       <= 0;
    holds_asked     <= holds_asked + 1;
    repeat (10) begin
      send_item(FUNC_TICK, 8'($urandom), 1'b0);
      send_item(FUNC_PAYLOAD, 8'($urandom), 1'b0);
    end
    wait_idle();

    // restore reset sync and decimation values, length 5, short run, and drain
    run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd5, DECIMATION_RST, 32, 32, 15);

    $display("run covered %0d input beats, %0d result beats checked, %0d frames closed",
             items_sent, beats_checked, frames_closed);
    $display("mix: lengths 0..73, decimation 0..65535, idle/stall mixes, long hold-off");
    if (mismatches == 0 && beats_due == 0) begin
      $display("decimated_crc16_frame_builder_top regression: pass");
    end else begin
      $display("decimated_crc16_frame_builder_top regression: fail");
    end
    $finish;
  end

endmodule

@@ decimated_crc16_frame_builder_top.f @@
+incdir+hw/rtl
hw/rtl/dcfb_pkg.sv
hw/rtl/decimated_crc16_frame_builder_top.sv
hw/rtl/dcfb_checker.sv
dv/frame_tb_pkg.sv
dv/frame_stream_check.sv
dv/testbench.sv
